[rtl/tmcw_pkg.sv]
// Shared types and constants for the UTF-8 text-mode cell writer.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CP_W    = 21;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = CP_W + COLOR_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_BYTE   = 3'd0,
        OP_SET_CURSOR = 3'd1,
        OP_SET_COLOR  = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_READ_CELL  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ
    } t_state;

    localparam logic [BYTE_W-1:0]  BYTE_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0]  BYTE_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0]  ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0]  LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0]  LEAD2_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0]  LEAD2_BITS  = 8'h1F;
    localparam logic [BYTE_W-1:0]  LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0]  LEAD3_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0]  LEAD3_BITS  = 8'h0F;
    localparam logic [BYTE_W-1:0]  LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0]  LEAD4_CODE  = 8'hF0;
    localparam logic [BYTE_W-1:0]  LEAD4_BITS  = 8'h07;
    localparam logic [BYTE_W-1:0]  CONT_BITS   = 8'h3F;
    localparam logic [CP_W-1:0]    SPACE_CP    = 21'h20;
    localparam logic [COLOR_W-1:0] CLEAR_COLOR = 8'd15;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;

    typedef struct packed {
        logic accept;         // input transaction taken this cycle
        logic sweep;          // write the swept cell and advance the sweep address
        logic fill_space;     // sweep writes space and colour 15, otherwise zero
        logic load_out;       // load the result register
        logic cell_from_mem;  // result cell fields come from the read data
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_status;

endpackage

`default_nettype wire

[rtl/tmcw_ctrl.sv]
// Controller state machine of the cell writer: handshakes, clearing sweeps
// and result register valid. Depends on tmcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tmcw_pkg::OP_W-1:0]     i_operation,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    input  wire tmcw_pkg::t_status             i_status,
    output tmcw_pkg::t_cmd                     o_cmd
);

    tmcw_pkg::t_state r_state;
    tmcw_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             accept;

    // A new transaction is taken only when the result register is free or
    // is being emptied in the same cycle.
    assign o_ready = (r_state == tmcw_pkg::ST_IDLE) && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tmcw_pkg::ST_INIT: begin
                if (i_status.sweep_last) begin
                    n_state = tmcw_pkg::ST_IDLE;
                end
            end
            tmcw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_operation == tmcw_pkg::OP_CLEAR) begin
                        n_state = tmcw_pkg::ST_CLEAR;
                    end else if (i_operation == tmcw_pkg::OP_READ_CELL) begin
                        n_state = tmcw_pkg::ST_READ;
                    end
                end
            end
            tmcw_pkg::ST_CLEAR: begin
                if (i_status.sweep_last) begin
                    n_state = tmcw_pkg::ST_IDLE;
                end
            end
            tmcw_pkg::ST_READ: begin
                n_state = tmcw_pkg::ST_IDLE;
            end
            default: begin
                n_state = tmcw_pkg::ST_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.accept      = accept;
        case (r_state)
            tmcw_pkg::ST_INIT: begin
                o_cmd.sweep = 1'b1;
            end
            tmcw_pkg::ST_IDLE: begin
                o_cmd.load_out = accept && (i_operation != tmcw_pkg::OP_CLEAR)
                                 && (i_operation != tmcw_pkg::OP_READ_CELL);
            end
            tmcw_pkg::ST_CLEAR: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.fill_space = 1'b1;
                o_cmd.load_out   = i_status.sweep_last;
            end
            tmcw_pkg::ST_READ: begin
                o_cmd.load_out      = 1'b1;
                o_cmd.cell_from_mem = 1'b1;
            end
            default: begin
                o_cmd.sweep = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmcw_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/tmcw_datapath.sv]
// Datapath of the cell writer: cell memory, cursor, colour, UTF-8 decoder,
// sweep address and result register. Depends on tmcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tmcw_pkg::t_cmd                   i_cmd,
    output tmcw_pkg::t_status                     o_status,
    input  wire logic [tmcw_pkg::OP_W-1:0]        i_operation,
    input  wire logic [tmcw_pkg::BYTE_W-1:0]      i_data_byte,
    input  wire logic [tmcw_pkg::COL_W-1:0]       i_pos_x,
    input  wire logic [tmcw_pkg::ROW_W-1:0]       i_pos_y,
    input  wire logic [tmcw_pkg::COLOR_W-1:0]     i_color_value,
    output logic      [tmcw_pkg::CP_W-1:0]        o_cell_char,
    output logic      [tmcw_pkg::COLOR_W-1:0]     o_cell_color,
    output logic      [tmcw_pkg::COL_W-1:0]       o_cursor_col,
    output logic      [tmcw_pkg::ROW_W-1:0]       o_cursor_row
);

    localparam int AW = tmcw_pkg::ADDR_W;

    logic [tmcw_pkg::CELL_W-1:0]  mem [tmcw_pkg::CELLS];

    logic [tmcw_pkg::COL_W-1:0]   r_col, n_col;
    logic [tmcw_pkg::ROW_W-1:0]   r_line, n_line;
    logic [tmcw_pkg::COLOR_W-1:0] r_color, n_color;
    logic [1:0]                   r_pend, n_pend;
    logic [tmcw_pkg::CP_W-1:0]    r_part, n_part;
    logic [AW-1:0]                r_sweep_addr;
    logic [tmcw_pkg::CELL_W-1:0]  r_rd_data;
    logic                         r_rd_ok;

    logic                         place;
    logic [tmcw_pkg::CP_W-1:0]    place_cp;
    logic                         put_wr;
    logic                         col_ok;
    logic [AW-1:0]                cursor_addr;
    logic [AW-1:0]                pos_addr;
    logic                         pos_ok;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tmcw_pkg::CELL_W-1:0]  mem_wdata;
    logic                         rd_en;
    logic [tmcw_pkg::BYTE_W-1:0]  b;

    assign b           = i_data_byte;
    assign col_ok      = r_col < tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS);
    assign cursor_addr = AW'(r_line) * AW'(tmcw_pkg::COLUMNS) + AW'(r_col);
    assign pos_addr    = AW'(i_pos_y) * AW'(tmcw_pkg::COLUMNS) + AW'(i_pos_x);
    assign pos_ok      = (i_pos_x < tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS))
                         && (i_pos_y < tmcw_pkg::ROW_W'(tmcw_pkg::ROWS));
    assign rd_en       = i_cmd.accept && (i_operation == tmcw_pkg::OP_READ_CELL);
    assign o_status.sweep_last = (r_sweep_addr == AW'(tmcw_pkg::CELLS - 1));

    always_comb begin
        n_col    = r_col;
        n_line   = r_line;
        n_color  = r_color;
        n_pend   = r_pend;
        n_part   = r_part;
        place    = 1'b0;
        place_cp = '0;
        if (i_cmd.accept) begin
            case (i_operation)
                tmcw_pkg::OP_PUT_BYTE: begin
                    if (r_pend != 2'd0) begin
                        // Every byte inside a sequence is a continuation, even controls.
                        n_part = {r_part[tmcw_pkg::CP_W-7:0], b[5:0] & tmcw_pkg::CONT_BITS[5:0]};
                        n_pend = r_pend - 2'd1;
                        if (r_pend == 2'd1) begin
                            place    = 1'b1;
                            place_cp = n_part;
                        end
                    end else if (b == tmcw_pkg::BYTE_LF) begin
                        n_col = '0;
                        if (r_line >= tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1)) begin
                            n_line = '0;
                        end else begin
                            n_line = r_line + tmcw_pkg::ROW_W'(1);
                        end
                    end else if (b == tmcw_pkg::BYTE_CR) begin
                        n_col = '0;
                    end else if (col_ok) begin
                        if (b < tmcw_pkg::ASCII_LIMIT) begin
                            place    = 1'b1;
                            place_cp = tmcw_pkg::CP_W'(b);
                        end else if ((b & tmcw_pkg::LEAD2_MASK) == tmcw_pkg::LEAD2_CODE) begin
                            n_part = tmcw_pkg::CP_W'(b & tmcw_pkg::LEAD2_BITS);
                            n_pend = 2'd1;
                        end else if ((b & tmcw_pkg::LEAD3_MASK) == tmcw_pkg::LEAD3_CODE) begin
                            n_part = tmcw_pkg::CP_W'(b & tmcw_pkg::LEAD3_BITS);
                            n_pend = 2'd2;
                        end else if ((b & tmcw_pkg::LEAD4_MASK) == tmcw_pkg::LEAD4_CODE) begin
                            n_part = tmcw_pkg::CP_W'(b & tmcw_pkg::LEAD4_BITS);
                            n_pend = 2'd3;
                        end else begin
                            place    = 1'b1;
                            place_cp = tmcw_pkg::CP_W'(b);
                        end
                    end
                end
                tmcw_pkg::OP_SET_CURSOR: begin
                    if (i_pos_x < tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS)) begin
                        n_col = i_pos_x;
                    end
                    if (i_pos_y < tmcw_pkg::ROW_W'(tmcw_pkg::ROWS)) begin
                        n_line = i_pos_y;
                    end
                end
                tmcw_pkg::OP_SET_COLOR: begin
                    n_color = i_color_value;
                end
                tmcw_pkg::OP_CLEAR: begin
                    n_col  = '0;
                    n_line = '0;
                end
                default: begin
                    n_color = r_color;
                end
            endcase
        end
        // A finished character past the last column is dropped.
        put_wr = place && col_ok;
        if (put_wr) begin
            n_col = r_col + tmcw_pkg::COL_W'(1);
        end
    end

    always_comb begin
        if (i_cmd.sweep) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep_addr;
            mem_wdata = i_cmd.fill_space ? {tmcw_pkg::SPACE_CP, tmcw_pkg::CLEAR_COLOR} : '0;
        end else begin
            mem_we    = put_wr;
            mem_waddr = cursor_addr;
            mem_wdata = {place_cp, r_color};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[pos_addr];
            r_rd_ok   <= pos_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_line       <= '0;
            r_color      <= tmcw_pkg::RESET_COLOR;
            r_pend       <= '0;
            r_part       <= '0;
            r_sweep_addr <= '0;
        end else begin
            r_col   <= n_col;
            r_line  <= n_line;
            r_color <= n_color;
            r_pend  <= n_pend;
            r_part  <= n_part;
            if (i_cmd.sweep) begin
                if (o_status.sweep_last) begin
                    r_sweep_addr <= '0;
                end else begin
                    r_sweep_addr <= r_sweep_addr + AW'(1);
                end
            end
        end
    end

    // The result always shows the cursor as it stands after the transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_cursor_col <= n_col;
            o_cursor_row <= n_line;
            if (i_cmd.cell_from_mem && r_rd_ok) begin
                o_cell_char  <= r_rd_data[tmcw_pkg::CELL_W-1:tmcw_pkg::COLOR_W];
                o_cell_color <= r_rd_data[tmcw_pkg::COLOR_W-1:0];
            end else begin
                o_cell_char  <= '0;
                o_cell_color <= '0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/utf8_text_mode_cell_writer.sv]
// Put byte, set cursor, set colour and unknown codes give their result in the cycle after
// acceptance; read cell first goes through the registered memory read; clear first sweeps
// all 2000 cells, one memory write per cell. Throughput is one transaction per cycle for
// all but read and clear while results are taken, set by the single write port of the
// memory. Reset is synchronous, active low; afterwards a pass over all cells zeroes the
// memory and o_ready stays low until it is done.
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_mode_cell_writer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [tmcw_pkg::OP_W-1:0]        i_operation,
    input  wire logic [tmcw_pkg::BYTE_W-1:0]      i_data_byte,
    input  wire logic [tmcw_pkg::COL_W-1:0]       i_pos_x,
    input  wire logic [tmcw_pkg::ROW_W-1:0]       i_pos_y,
    input  wire logic [tmcw_pkg::COLOR_W-1:0]     i_color_value,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic      [tmcw_pkg::CP_W-1:0]        o_cell_char,
    output logic      [tmcw_pkg::COLOR_W-1:0]     o_cell_color,
    output logic      [tmcw_pkg::COL_W-1:0]       o_cursor_col,
    output logic      [tmcw_pkg::ROW_W-1:0]       o_cursor_row
);

    tmcw_pkg::t_cmd    cmd;
    tmcw_pkg::t_status status;

    tmcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tmcw_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (i_operation),
        .i_data_byte   (i_data_byte),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_color_value (i_color_value),
        .o_cell_char   (o_cell_char),
        .o_cell_color  (o_cell_color),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_row  (o_cursor_row)
    );

endmodule

`default_nettype wire

[rtl/tmcw_checker.sv]
// Port-level checker for the cell writer, bound to the top level.
// Depends on tmcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic                             o_ready,
    input  wire logic [tmcw_pkg::OP_W-1:0]        i_operation,
    input  wire logic                             o_valid,
    input  wire logic                             i_ready,
    input  wire logic [tmcw_pkg::CP_W-1:0]        o_cell_char,
    input  wire logic [tmcw_pkg::COLOR_W-1:0]     o_cell_color,
    input  wire logic [tmcw_pkg::COL_W-1:0]       o_cursor_col,
    input  wire logic [tmcw_pkg::ROW_W-1:0]       o_cursor_row
);

    // A stalled result transaction must keep its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cell_char) && $stable(o_cell_color)
            && $stable(o_cursor_col) && $stable(o_cursor_row))
        else $error("result payload changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_col <= tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS))
            && (o_cursor_row < tmcw_pkg::ROW_W'(tmcw_pkg::ROWS)))
        else $error("cursor outside the buffer");

    // Colour changes are answered in the next cycle with empty cell fields.
    a_color_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_operation == tmcw_pkg::OP_SET_COLOR)
            |=> o_valid && (o_cell_char == '0) && (o_cell_color == '0))
        else $error("set colour result missing or not empty");

    // A clear sweeps the memory, so nothing is taken in the following cycle.
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_operation == tmcw_pkg::OP_CLEAR) |=> !o_ready)
        else $error("transaction accepted during clear");

endmodule

bind utf8_text_mode_cell_writer tmcw_checker u_tmcw_checker (.*);

`default_nettype wire

[tb/tb_utf8_text_mode_cell_writer.sv]
// Self-checking testbench for the UTF-8 text-mode cell writer: a behavioural model of the
// cell buffer predicts every result transaction and a checker compares each field.
// Depends on tmcw_pkg and utf8_text_mode_cell_writer.
`timescale 1ns / 1ps

module tb_utf8_text_mode_cell_writer;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int IDLE_LIMIT      = 20000;
    localparam int RANDOM_ITEMS    = 1320;
    localparam int MAX_CLEARS      = 4;
    localparam int TAIL_CYCLES     = 8;
    localparam int FIRST_UNUSED_OP = int'(tmcw_pkg::OP_READ_CELL) + 1;
    localparam int OP_CODES        = 1 << tmcw_pkg::OP_W;

    typedef struct packed {
        logic [tmcw_pkg::CP_W-1:0]    ch;
        logic [tmcw_pkg::COLOR_W-1:0] color;
        logic [tmcw_pkg::COL_W-1:0]   col;
        logic [tmcw_pkg::ROW_W-1:0]   row;
    } t_cell_result;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} t_rx_mode;

    logic                         i_clk         = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         in_valid      = 1'b0;
    logic                         in_ready;
    logic [tmcw_pkg::OP_W-1:0]    operation     = '0;
    logic [tmcw_pkg::BYTE_W-1:0]  data_byte     = '0;
    logic [tmcw_pkg::COL_W-1:0]   pos_x         = '0;
    logic [tmcw_pkg::ROW_W-1:0]   pos_y         = '0;
    logic [tmcw_pkg::COLOR_W-1:0] color_value   = '0;
    logic                         out_valid;
    logic                         out_ready     = 1'b0;
    logic [tmcw_pkg::CP_W-1:0]    cell_char;
    logic [tmcw_pkg::COLOR_W-1:0] cell_color;
    logic [tmcw_pkg::COL_W-1:0]   cursor_col;
    logic [tmcw_pkg::ROW_W-1:0]   cursor_row;

    // Model of the buffer, advanced once per accepted input transaction.
    logic [tmcw_pkg::CP_W-1:0]    shadow_char  [tmcw_pkg::CELLS];
    logic [tmcw_pkg::COLOR_W-1:0] shadow_color [tmcw_pkg::CELLS];
    logic [tmcw_pkg::COL_W-1:0]   cur_col;
    logic [tmcw_pkg::ROW_W-1:0]   cur_row;
    logic [tmcw_pkg::COLOR_W-1:0] pen_color;
    logic [1:0]                   cont_left;
    logic [tmcw_pkg::CP_W-1:0]    cp_acc;
    t_cell_result                 pending_cells [$];

    int burst_left      = 0;
    int sent_items      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;
    int clear_count     = 0;
    int op_seen [OP_CODES] = '{default: 0};

    utf8_text_mode_cell_writer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_operation   (operation),
        .i_data_byte   (data_byte),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .i_color_value (color_value),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_cell_char   (cell_char),
        .o_cell_color  (cell_color),
        .o_cursor_col  (cursor_col),
        .o_cursor_row  (cursor_row)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic void reset_model();
        foreach (shadow_char[i]) begin
            shadow_char[i]  = '0;
            shadow_color[i] = '0;
        end
        cur_col   = '0;
        cur_row   = '0;
        pen_color = tmcw_pkg::RESET_COLOR;
        cont_left = '0;
        cp_acc    = '0;
    endfunction

    function automatic void write_cell(input logic [tmcw_pkg::CP_W-1:0] cp);
        int idx;
        if (cur_col < tmcw_pkg::COLUMNS && cur_row < tmcw_pkg::ROWS) begin
            idx               = int'(cur_row) * tmcw_pkg::COLUMNS + int'(cur_col);
            shadow_char[idx]  = cp;
            shadow_color[idx] = pen_color;
            cur_col           = cur_col + 1'b1;
        end
    endfunction

    function automatic void decode_byte(input logic [tmcw_pkg::BYTE_W-1:0] b);
        if (cont_left != 0) begin
            // Inside a sequence every byte is a continuation, control bytes included.
            cp_acc    = (cp_acc << 6) | tmcw_pkg::CP_W'(b & tmcw_pkg::CONT_BITS);
            cont_left = cont_left - 1'b1;
            if (cont_left == 0)
                write_cell(cp_acc);
        end else if (b == tmcw_pkg::BYTE_LF) begin
            cur_col = '0;
            if (int'(cur_row) + 1 >= tmcw_pkg::ROWS)
                cur_row = '0;
            else
                cur_row = cur_row + 1'b1;
        end else if (b == tmcw_pkg::BYTE_CR) begin
            cur_col = '0;
        end else if (cur_col < tmcw_pkg::COLUMNS && cur_row < tmcw_pkg::ROWS) begin
            if (b < tmcw_pkg::ASCII_LIMIT) begin
                write_cell(tmcw_pkg::CP_W'(b));
            end else if ((b & tmcw_pkg::LEAD2_MASK) == tmcw_pkg::LEAD2_CODE) begin
                cp_acc    = tmcw_pkg::CP_W'(b & tmcw_pkg::LEAD2_BITS);
                cont_left = 2'd1;
            end else if ((b & tmcw_pkg::LEAD3_MASK) == tmcw_pkg::LEAD3_CODE) begin
                cp_acc    = tmcw_pkg::CP_W'(b & tmcw_pkg::LEAD3_BITS);
                cont_left = 2'd2;
            end else if ((b & tmcw_pkg::LEAD4_MASK) == tmcw_pkg::LEAD4_CODE) begin
                cp_acc    = tmcw_pkg::CP_W'(b & tmcw_pkg::LEAD4_BITS);
                cont_left = 2'd3;
            end else begin
                write_cell(tmcw_pkg::CP_W'(b));
            end
        end
    endfunction

    function automatic t_cell_result predict_cell_result(
        input logic [tmcw_pkg::OP_W-1:0]    op,
        input logic [tmcw_pkg::BYTE_W-1:0]  b,
        input logic [tmcw_pkg::COL_W-1:0]   px,
        input logic [tmcw_pkg::ROW_W-1:0]   py,
        input logic [tmcw_pkg::COLOR_W-1:0] colv
    );
        t_cell_result r;
        r = '0;
        case (op)
            tmcw_pkg::OP_PUT_BYTE: begin
                decode_byte(b);
            end
            tmcw_pkg::OP_SET_CURSOR: begin
                if (px < tmcw_pkg::COLUMNS)
                    cur_col = px;
                if (py < tmcw_pkg::ROWS)
                    cur_row = py;
            end
            tmcw_pkg::OP_SET_COLOR: begin
                pen_color = colv;
            end
            tmcw_pkg::OP_CLEAR: begin
                foreach (shadow_char[i]) begin
                    shadow_char[i]  = tmcw_pkg::SPACE_CP;
                    shadow_color[i] = tmcw_pkg::CLEAR_COLOR;
                end
                cur_col = '0;
                cur_row = '0;
            end
            tmcw_pkg::OP_READ_CELL: begin
                if (px < tmcw_pkg::COLUMNS && py < tmcw_pkg::ROWS) begin
                    r.ch    = shadow_char[int'(py) * tmcw_pkg::COLUMNS + int'(px)];
                    r.color = shadow_color[int'(py) * tmcw_pkg::COLUMNS + int'(px)];
                end
            end
            default: begin
            end
        endcase
        r.col = cur_col;
        r.row = cur_row;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("At %0t: %s differs, got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Prediction happens at the edge where the input transaction is taken.
    always @(posedge i_clk) begin
        if (rst_n && in_valid && in_ready) begin
            pending_cells.push_back(predict_cell_result(operation, data_byte, pos_x, pos_y,
                                                        color_value));
            op_seen[operation]++;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_cell_result want;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (pending_cells.size() == 0) begin
                report_mismatch("unexpected result", 32'(cell_char), 32'd0);
            end else begin
                want = pending_cells.pop_front();
                if (cell_char !== want.ch)
                    report_mismatch("cell_char", 32'(cell_char), 32'(want.ch));
                if (cell_color !== want.color)
                    report_mismatch("cell_color", 32'(cell_color), 32'(want.color));
                if (cursor_col !== want.col)
                    report_mismatch("cursor_col", 32'(cursor_col), 32'(want.col));
                if (cursor_row !== want.row)
                    report_mismatch("cursor_row", 32'(cursor_row), 32'(want.row));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver switches at random between stall behaviours.
    initial begin : receiver_stalls
        t_rx_mode mode;
        int       span;
        int       phase;
        phase = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(64, 256);
            repeat (span) begin
                @(negedge i_clk);
                phase++;
                case (mode)
                    RX_ALWAYS:      out_ready = 1'b1;
                    RX_COIN:        out_ready = 1'($urandom_range(0, 1));
                    RX_ONE_IN_FOUR: out_ready = (phase % 4 == 0);
                    default:        out_ready = ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // Called and left at a falling edge; valid stays high between transactions of a burst.
    task automatic send_item(input logic [tmcw_pkg::OP_W-1:0] op,
                             input logic [tmcw_pkg::BYTE_W-1:0] b,
                             input logic [tmcw_pkg::COL_W-1:0] px,
                             input logic [tmcw_pkg::ROW_W-1:0] py,
                             input logic [tmcw_pkg::COLOR_W-1:0] colv);
        int gap;
        if (burst_left == 0) begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(60, 200);
            else
                burst_left = $urandom_range(1, 16);
        end
        operation   = op;
        data_byte   = b;
        pos_x       = px;
        pos_y       = py;
        color_value = colv;
        in_valid    = 1'b1;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        burst_left--;
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic put_byte(input logic [tmcw_pkg::BYTE_W-1:0] b);
        send_item(tmcw_pkg::OP_PUT_BYTE, b, tmcw_pkg::COL_W'($urandom),
                  tmcw_pkg::ROW_W'($urandom), tmcw_pkg::COLOR_W'($urandom));
    endtask

    task automatic send_command(input logic [tmcw_pkg::OP_W-1:0] op,
                                input logic [tmcw_pkg::COL_W-1:0] px,
                                input logic [tmcw_pkg::ROW_W-1:0] py,
                                input logic [tmcw_pkg::COLOR_W-1:0] colv);
        send_item(op, tmcw_pkg::BYTE_W'($urandom), px, py, colv);
    endtask

    // A command other than put byte, with random fields, used to break into sequences.
    task automatic send_random_command();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            send_command(tmcw_pkg::OP_SET_COLOR, tmcw_pkg::COL_W'($urandom),
                         tmcw_pkg::ROW_W'($urandom), tmcw_pkg::COLOR_W'($urandom));
        else if (pick == 1)
            send_command(tmcw_pkg::OP_SET_CURSOR,
                         tmcw_pkg::COL_W'($urandom_range(0, tmcw_pkg::COLUMNS - 1)),
                         tmcw_pkg::ROW_W'($urandom_range(0, tmcw_pkg::ROWS - 1)),
                         tmcw_pkg::COLOR_W'($urandom));
        else if (pick == 2)
            send_command(tmcw_pkg::OP_READ_CELL, tmcw_pkg::COL_W'($urandom),
                         tmcw_pkg::ROW_W'($urandom), tmcw_pkg::COLOR_W'($urandom));
        else
            send_command(tmcw_pkg::OP_W'($urandom_range(FIRST_UNUSED_OP, OP_CODES - 1)),
                         tmcw_pkg::COL_W'($urandom), tmcw_pkg::ROW_W'($urandom),
                         tmcw_pkg::COLOR_W'($urandom));
    endtask

    // One character of len bytes; a broken one may be cut short or have a command inside it.
    task automatic send_utf8_char(input int len, input bit broken);
        logic [tmcw_pkg::BYTE_W-1:0] lead;
        logic [tmcw_pkg::BYTE_W-1:0] cont;
        int                          conts;
        case (len)
            1: lead = tmcw_pkg::BYTE_W'($urandom_range(0, int'(tmcw_pkg::ASCII_LIMIT) - 1));
            2: lead = tmcw_pkg::LEAD2_CODE
                      | (tmcw_pkg::BYTE_W'($urandom) & tmcw_pkg::LEAD2_BITS);
            3: lead = tmcw_pkg::LEAD3_CODE
                      | (tmcw_pkg::BYTE_W'($urandom) & tmcw_pkg::LEAD3_BITS);
            default: lead = tmcw_pkg::LEAD4_CODE
                            | (tmcw_pkg::BYTE_W'($urandom) & tmcw_pkg::LEAD4_BITS);
        endcase
        put_byte(lead);
        conts = broken ? $urandom_range(0, len - 1) : len - 1;
        for (int k = 0; k < conts; k++) begin
            if (broken && $urandom_range(0, 1) == 1)
                send_random_command();
            if ($urandom_range(0, 9) == 0)
                cont = tmcw_pkg::BYTE_W'($urandom);
            else
                cont = tmcw_pkg::ASCII_LIMIT
                       | (tmcw_pkg::BYTE_W'($urandom) & tmcw_pkg::CONT_BITS);
            put_byte(cont);
        end
    endtask

    task automatic test_utf8_decoding();
        put_byte(8'h41);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'hC3);
        put_byte(8'hA9);
        put_byte(8'hE2);
        put_byte(8'h82);
        put_byte(8'hAC);
        put_byte(8'hF0);
        put_byte(8'h9F);
        put_byte(8'h98);
        put_byte(8'h80);
    endtask

    task automatic test_line_control();
        send_command(tmcw_pkg::OP_SET_CURSOR, tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1),
                     tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1), tmcw_pkg::COLOR_W'($urandom));
        put_byte(8'hC3);
        // The newline completes the sequence and the character lands in the last column.
        put_byte(tmcw_pkg::BYTE_LF);
        put_byte(8'hE2);
        put_byte(tmcw_pkg::BYTE_CR);
        put_byte(tmcw_pkg::BYTE_LF);
    endtask

    task automatic test_command_interplay();
        send_command(tmcw_pkg::OP_SET_CURSOR, '1, '1, tmcw_pkg::COLOR_W'($urandom));
        put_byte(8'hE2);
        send_command(tmcw_pkg::OP_SET_COLOR, tmcw_pkg::COL_W'($urandom),
                     tmcw_pkg::ROW_W'($urandom), '0);
        send_command(tmcw_pkg::OP_SET_CURSOR, tmcw_pkg::COL_W'(10), tmcw_pkg::ROW_W'(3),
                     tmcw_pkg::COLOR_W'($urandom));
        put_byte(8'h82);
        put_byte(8'hAC);
        send_command(tmcw_pkg::OP_READ_CELL, tmcw_pkg::COL_W'(10), tmcw_pkg::ROW_W'(3),
                     tmcw_pkg::COLOR_W'($urandom));
        send_command(tmcw_pkg::OP_READ_CELL, '1, '1, tmcw_pkg::COLOR_W'($urandom));
        send_command(tmcw_pkg::OP_W'(OP_CODES - 1), '1, '1, '1);
        send_command(tmcw_pkg::OP_CLEAR, tmcw_pkg::COL_W'($urandom),
                     tmcw_pkg::ROW_W'($urandom), tmcw_pkg::COLOR_W'($urandom));
    endtask

    task automatic test_random_traffic(input int item_count);
        int first;
        int kind;
        int sel;
        first = sent_items;
        while (sent_items - first < item_count) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                send_utf8_char(($urandom_range(0, 9) < 5) ? 1 : $urandom_range(2, 4), 1'b0);
            end else if (kind < 48) begin
                put_byte(($urandom_range(0, 1) == 1) ? tmcw_pkg::BYTE_LF : tmcw_pkg::BYTE_CR);
            end else if (kind < 58) begin
                sel = $urandom_range(0, 19);
                if (sel < 4)
                    send_command(tmcw_pkg::OP_SET_CURSOR,
                                 tmcw_pkg::COL_W'($urandom_range(tmcw_pkg::COLUMNS - 4,
                                                                 tmcw_pkg::COLUMNS - 1)),
                                 tmcw_pkg::ROW_W'($urandom_range(0, tmcw_pkg::ROWS - 1)),
                                 tmcw_pkg::COLOR_W'($urandom));
                else if (sel < 17)
                    send_command(tmcw_pkg::OP_SET_CURSOR,
                                 tmcw_pkg::COL_W'($urandom_range(0, tmcw_pkg::COLUMNS - 1)),
                                 tmcw_pkg::ROW_W'($urandom_range(0, tmcw_pkg::ROWS - 1)),
                                 tmcw_pkg::COLOR_W'($urandom));
                else
                    send_command(tmcw_pkg::OP_SET_CURSOR, tmcw_pkg::COL_W'($urandom),
                                 tmcw_pkg::ROW_W'($urandom), tmcw_pkg::COLOR_W'($urandom));
            end else if (kind < 63) begin
                send_command(tmcw_pkg::OP_SET_COLOR, tmcw_pkg::COL_W'($urandom),
                             tmcw_pkg::ROW_W'($urandom), tmcw_pkg::COLOR_W'($urandom));
            end else if (kind < 86 || (kind >= 98 && clear_count >= MAX_CLEARS)) begin
                // Half the time, if the cursor is past column 0, read back the cell just written.
                sel = $urandom_range(0, 9);
                if (sel < 5 && cur_col > 0)
                    send_command(tmcw_pkg::OP_READ_CELL, cur_col - 1'b1, cur_row,
                                 tmcw_pkg::COLOR_W'($urandom));
                else if (sel < 9)
                    send_command(tmcw_pkg::OP_READ_CELL,
                                 tmcw_pkg::COL_W'($urandom_range(0, tmcw_pkg::COLUMNS - 1)),
                                 tmcw_pkg::ROW_W'($urandom_range(0, tmcw_pkg::ROWS - 1)),
                                 tmcw_pkg::COLOR_W'($urandom));
                else
                    send_command(tmcw_pkg::OP_READ_CELL, tmcw_pkg::COL_W'($urandom),
                                 tmcw_pkg::ROW_W'($urandom), tmcw_pkg::COLOR_W'($urandom));
            end else if (kind < 93) begin
                put_byte(tmcw_pkg::BYTE_W'($urandom));
            end else if (kind < 96) begin
                send_utf8_char($urandom_range(2, 4), 1'b1);
            end else if (kind < 98) begin
                send_random_command();
            end else begin
                clear_count++;
                send_command(tmcw_pkg::OP_CLEAR, tmcw_pkg::COL_W'($urandom),
                             tmcw_pkg::ROW_W'($urandom), tmcw_pkg::COLOR_W'($urandom));
            end
        end
    endtask

    task automatic test_drain_pause();
        in_valid = 1'b0;
        while (pending_cells.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin : run
        int unused_ops;
        unused_ops = 0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        test_utf8_decoding();
        test_line_control();
        test_command_interplay();
        test_random_traffic(RANDOM_ITEMS / 2);
        test_drain_pause();
        test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        in_valid = 1'b0;
        while (pending_cells.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        for (int k = FIRST_UNUSED_OP; k < OP_CODES; k++)
            unused_ops += op_seen[k];
        $display("Sent %0d transactions: %0d put byte, %0d set cursor, %0d set colour,",
                 sent_items, op_seen[tmcw_pkg::OP_PUT_BYTE], op_seen[tmcw_pkg::OP_SET_CURSOR],
                 op_seen[tmcw_pkg::OP_SET_COLOR]);
        $display("%0d clear, %0d read cell, %0d unused codes; %0d results checked, %0d bad",
                 op_seen[tmcw_pkg::OP_CLEAR], op_seen[tmcw_pkg::OP_READ_CELL],
                 unused_ops, results_checked, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/tmcw_pkg.sv
rtl/tmcw_ctrl.sv
rtl/tmcw_datapath.sv
rtl/utf8_text_mode_cell_writer.sv
rtl/tmcw_checker.sv
tb/tb_utf8_text_mode_cell_writer.sv
